// ----- sv/periodic_oneshot_timer_table_top_defines.svh -----
// ----------------------------------------------------------------------------
// timer table assertion macros
// shared property wrappers for the timer table rtl
// ----------------------------------------------------------------------------
`ifndef PERIODIC_ONESHOT_TIMER_TABLE_TOP_DEFINES_SVH
`define PERIODIC_ONESHOT_TIMER_TABLE_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define POTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define POTT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pott_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer table package
// field widths, codes and defaults shared by the timer table rtl
// ----------------------------------------------------------------------------
package pott_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam int OP_W       = 2;
  localparam int IV_W       = 32;
  localparam int HANDLE_W   = 4;
  localparam int MINIV_W    = 16;
  localparam int KIND_W     = 2;
  localparam int SLOT_OUT_W = 4;
  localparam int STATUS_W   = 2;
  localparam int OUT_TIME_W = 32;

  localparam logic [MINIV_W-1:0] MIN_INTERVAL_RST = 16'd15;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_USED = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [SLOT_OUT_W-1:0] slot;
    logic [STATUS_W-1:0]   status;
    logic                  has_pending;
    logic [OUT_TIME_W-1:0] next_deadline;
    logic                  last;
  } result_t;

endpackage

// ----- sv/pott_slot_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer slot memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pott_slot_ram #(
  parameter int DEPTH  = pott_pkg::SLOTS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int DATA_W = 1 + 2 * pott_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/periodic_oneshot_timer_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic / one-shot timer table
// slot table with add, remove and tick operations over a slot memory
// ----------------------------------------------------------------------------
// Add and remove are accepted in the idle state, then the reply is loaded
// into the output register. A tick walks every slot through the single read
// port of the slot memory, one slot per cycle while no fired result is held
// at a stalled output. A reply, fired result or tick summary that meets a
// stalled output waits there until the output can take it.
// Periods, deadlines and one-shot marks live in the memory, valid marks in
// flops, so the table is empty right after reset with no clearing pass. The
// next transaction is accepted while a result still sits in the output
// register. min_interval may be written at any time the block is idle;
// cfg_ready is always high.
module periodic_oneshot_timer_table_top #(
  parameter int SLOTS     = pott_pkg::SLOTS_DEF,
  parameter int TIME_BITS = pott_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pott_pkg::OP_W-1:0]         in_opcode,
  input  logic [pott_pkg::IV_W-1:0]         in_interval_ticks,
  input  logic                              in_one_shot,
  input  logic [pott_pkg::HANDLE_W-1:0]     in_handle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pott_pkg::KIND_W-1:0]       out_kind,
  output logic [pott_pkg::SLOT_OUT_W-1:0]   out_slot,
  output logic [pott_pkg::STATUS_W-1:0]     out_status,
  output logic                              out_has_pending,
  output logic [pott_pkg::OUT_TIME_W-1:0]   out_next_deadline,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pott_pkg::MINIV_W-1:0]      cfg_min_interval
);

  import pott_pkg::*;

  `include "periodic_oneshot_timer_table_top_defines.svh"

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENT_W  = 1 + 2 * TIME_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_SUM  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [TIME_BITS-1:0]   now_r, now_nxt;
  logic [SLOTS-1:0]       valid_r, valid_nxt;
  logic [MINIV_W-1:0]     min_iv_r;
  logic [OP_W-1:0]        op_r, op_nxt;
  logic [IV_W-1:0]        iv_r, iv_nxt;
  logic                   once_r, once_nxt;
  logic [HANDLE_W-1:0]    handle_r, handle_nxt;
  logic [SLOT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                   rd_more_r, rd_more_nxt;
  logic                   ev_vld_r, ev_vld_nxt;
  logic [SLOT_W-1:0]      ev_idx_r, ev_idx_nxt;
  logic                   pend_r, pend_nxt;
  logic [TIME_BITS-1:0]   best_r, best_nxt;
  logic [TIME_BITS-1:0]   best_dist_r, best_dist_nxt;
  logic                   out_valid_r, out_valid_nxt;
  result_t                out_r;

  // slot memory port
  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [ENT_W-1:0]       ram_wdata;
  logic                   ram_re;
  logic [ENT_W-1:0]       ram_rdata;

  logic                   rd_once;
  logic [TIME_BITS-1:0]   rd_period;
  logic [TIME_BITS-1:0]   rd_dl;
  logic [TIME_BITS-1:0]   due_diff;
  logic                   due;
  logic [TIME_BITS-1:0]   rearm_dl;
  logic [TIME_BITS-1:0]   new_dl;
  logic [TIME_BITS-1:0]   ahead_dist;
  logic                   ev_live;
  logic                   ev_fire;
  logic                   keep;
  logic                   hold;
  logic                   out_free;
  logic                   out_load;
  result_t                res;

  logic                   full;
  logic [SLOT_W-1:0]      free_idx;
  logic [IV_W-1:0]        iv_min;
  logic [IV_W-1:0]        iv_sel;
  logic [TIME_BITS-1:0]   iv_t;
  logic [TIME_BITS-1:0]   add_dl;
  logic                   h_in_range;
  logic [SLOT_W-1:0]      h_idx;
  logic                   rm_ok;

  pott_slot_ram #(
    .DEPTH  (SLOTS),
    .ADDR_W (SLOT_W),
    .DATA_W (ENT_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // evaluation of the slot last read from the slot memory
  assign rd_once    = ram_rdata[ENT_W-1];
  assign rd_period  = ram_rdata[2*TIME_BITS-1:TIME_BITS];
  assign rd_dl      = ram_rdata[TIME_BITS-1:0];
  assign due_diff   = now_r - rd_dl;
  assign due        = !due_diff[TIME_BITS-1];
  assign rearm_dl   = now_r + rd_period;
  assign new_dl     = due ? rearm_dl : rd_dl;
  // a rearmed slot lies exactly one period ahead
  assign ahead_dist = due ? rd_period : (rd_dl - now_r);
  assign ev_live    = ev_vld_r && valid_r[ev_idx_r];
  assign ev_fire    = ev_live && due;
  assign keep       = ev_live && !(due && rd_once);
  assign out_free   = !out_valid_r || !out_stall;
  assign hold       = ev_fire && !out_free;

  // lowest free slot
  always_comb begin
    full     = 1'b1;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        full     = 1'b0;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign iv_min     = IV_W'(min_iv_r);
  assign iv_sel     = (iv_r < iv_min) ? iv_min : iv_r;
  assign iv_t       = TIME_BITS'(iv_sel);
  assign add_dl     = now_r + iv_t;
  assign h_in_range = 32'(handle_r) < 32'(SLOTS);
  assign h_idx      = SLOT_W'(handle_r);
  assign rm_ok      = h_in_range && valid_r[h_idx];

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    valid_nxt     = valid_r;
    op_nxt        = op_r;
    iv_nxt        = iv_r;
    once_nxt      = once_r;
    handle_nxt    = handle_r;
    rd_idx_nxt    = rd_idx_r;
    rd_more_nxt   = rd_more_r;
    ev_vld_nxt    = ev_vld_r;
    ev_idx_nxt    = ev_idx_r;
    pend_nxt      = pend_r;
    best_nxt      = best_r;
    best_dist_nxt = best_dist_r;
    ram_we        = 1'b0;
    ram_waddr     = ev_idx_r;
    ram_wdata     = {rd_once, rd_period, rearm_dl};
    ram_re        = 1'b0;
    out_load      = 1'b0;
    res           = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_opcode;
          iv_nxt     = in_interval_ticks;
          once_nxt   = in_one_shot;
          handle_nxt = in_handle;
          if (in_opcode == OP_TICK) begin
            now_nxt       = now_r + TIME_BITS'(1);
            rd_idx_nxt    = '0;
            rd_more_nxt   = 1'b1;
            ev_vld_nxt    = 1'b0;
            pend_nxt      = 1'b0;
            best_nxt      = '0;
            best_dist_nxt = '0;
            state_nxt     = S_SCAN;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        case (op_r)
          OP_ADD: begin
            if (out_free) begin
              out_load  = 1'b1;
              res.kind  = KIND_ADD;
              res.last  = 1'b1;
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                res.slot             = SLOT_OUT_W'(free_idx);
                res.status           = STAT_OK;
                valid_nxt[free_idx]  = 1'b1;
                ram_we               = 1'b1;
                ram_waddr            = free_idx;
                ram_wdata            = {once_r, iv_t, add_dl};
              end
              state_nxt = S_IDLE;
            end
          end
          OP_REMOVE: begin
            if (out_free) begin
              out_load = 1'b1;
              res.kind = KIND_REMOVE;
              res.slot = handle_r;
              res.last = 1'b1;
              if (rm_ok) begin
                res.status       = STAT_OK;
                valid_nxt[h_idx] = 1'b0;
              end else begin
                res.status = STAT_NOT_USED;
              end
              state_nxt = S_IDLE;
            end
          end
          default: begin
            // unused opcode: no result
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        if (!hold) begin
          if (rd_more_r) begin
            ram_re      = 1'b1;
            rd_idx_nxt  = rd_idx_r + SLOT_W'(1);
            rd_more_nxt = (rd_idx_r != SLOT_W'(SLOTS - 1));
          end
          ev_vld_nxt = rd_more_r;
          ev_idx_nxt = rd_idx_r;
          if (ev_fire) begin
            out_load = 1'b1;
            res.kind = KIND_FIRED;
            res.slot = SLOT_OUT_W'(ev_idx_r);
            if (rd_once) begin
              valid_nxt[ev_idx_r] = 1'b0;
            end else begin
              ram_we = 1'b1;
            end
          end
          if (keep && (!pend_r || ahead_dist < best_dist_r)) begin
            pend_nxt      = 1'b1;
            best_dist_nxt = ahead_dist;
            best_nxt      = new_dl;
          end
          if (!rd_more_r && !ev_vld_r) begin
            state_nxt = S_SUM;
          end
        end
      end

      S_SUM: begin
        if (out_free) begin
          out_load          = 1'b1;
          res.kind          = KIND_SUMMARY;
          res.status        = STAT_OK;
          res.has_pending   = pend_r;
          res.next_deadline = OUT_TIME_W'(best_r);
          res.last          = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      valid_r     <= '0;
      min_iv_r    <= MIN_INTERVAL_RST;
      rd_more_r   <= 1'b0;
      ev_vld_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      valid_r     <= valid_nxt;
      rd_more_r   <= rd_more_nxt;
      ev_vld_r    <= ev_vld_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        min_iv_r <= cfg_min_interval;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    iv_r        <= iv_nxt;
    once_r      <= once_nxt;
    handle_r    <= handle_nxt;
    rd_idx_r    <= rd_idx_nxt;
    ev_idx_r    <= ev_idx_nxt;
    best_r      <= best_nxt;
    best_dist_r <= best_dist_nxt;
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_slot          = out_r.slot;
  assign out_status        = out_r.status;
  assign out_has_pending   = out_r.has_pending;
  assign out_next_deadline = out_r.next_deadline;
  assign out_last          = out_r.last;

  `POTT_ASSERT_NXT(a_tick_start, clk, rst_n,
    state_r == S_IDLE && in_valid && in_opcode == OP_TICK,
    state_r == S_SCAN && now_r == $past(now_r) + TIME_BITS'(1),
    "tick did not advance time and start the scan")
  `POTT_ASSERT_NXT(a_hold_keeps_slot, clk, rst_n,
    state_r == S_SCAN && hold,
    ev_vld_r && $stable(ev_idx_r) && $stable(rd_idx_r),
    "scan moved on while a fired result was held")
  `POTT_ASSERT_NXT(a_scan_done, clk, rst_n,
    state_r == S_SCAN && !rd_more_r && !ev_vld_r,
    state_r == S_SUM,
    "scan finished without reaching the summary")
  `POTT_ASSERT_IMP(a_fired_in_scan, clk, rst_n,
    out_load && res.kind == KIND_FIRED,
    state_r == S_SCAN && ev_live,
    "fired result from a slot that is not armed")

endmodule

// ----- tb/sv/periodic_oneshot_timer_table_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer table testbench
// sends add, remove and tick transactions into the timer table, tracks its
// own copy of the slot table, and checks every reply, firing and tick summary
// in order while both sides idle and stall at random
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_table_top_tb;
  import pott_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 22;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [OP_W-1:0] in_opcode;
  logic [IV_W-1:0] in_interval_ticks;
  logic in_one_shot;
  logic [HANDLE_W-1:0] in_handle;
  logic out_valid;
  logic out_stall;
  logic [KIND_W-1:0] out_kind;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [STATUS_W-1:0] out_status;
  logic out_has_pending;
  logic [OUT_TIME_W-1:0] out_next_deadline;
  logic out_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [MINIV_W-1:0] cfg_min_interval;

  // own copy of the timer table
  logic [31:0] now_ticks;
  logic armed[NSLOT];
  logic once_mark[NSLOT];
  logic [31:0] period_ticks[NSLOT];
  logic [31:0] deadline[NSLOT];
  logic [MINIV_W-1:0] min_ticks;

  result_t owed_replies[$];
  int idle_pct = 35;
  int mismatch_count = 0;
  int cycle_count = 0;
  int n_add = 0, n_full = 0, n_remove = 0, n_not_used = 0, n_tick = 0, n_fired = 0;

  periodic_oneshot_timer_table_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_interval_ticks(in_interval_ticks),
    .in_one_shot      (in_one_shot),
    .in_handle        (in_handle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_slot         (out_slot),
    .out_status       (out_status),
    .out_has_pending  (out_has_pending),
    .out_next_deadline(out_next_deadline),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_min_interval (cfg_min_interval)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               owed_replies.size());
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
  end

  function automatic result_t make_reply(input logic [KIND_W-1:0] kind,
                                         input logic [SLOT_OUT_W-1:0] slot,
                                         input logic [STATUS_W-1:0] status,
                                         input logic pend,
                                         input logic [OUT_TIME_W-1:0] next,
                                         input logic last);
    result_t r;
    r.kind = kind;
    r.slot = slot;
    r.status = status;
    r.has_pending = pend;
    r.next_deadline = next;
    r.last = last;
    return r;
  endfunction

  // appends one expected result at the tail of the queue
  function automatic void owe_reply(input result_t r);
    owed_replies = {owed_replies, r};
  endfunction

  // applies one accepted transaction to the table copy and queues its results
  task automatic advance_timer_table(input logic [OP_W-1:0] op, input logic [IV_W-1:0] iv_in,
                                     input logic os, input logic [HANDLE_W-1:0] h);
    logic [31:0] iv, lag, ahead, best_ahead, best_dl;
    logic pend;
    int free_idx;
    case (op)
      OP_ADD: begin
        n_add++;
        iv = (iv_in < {16'd0, min_ticks}) ? {16'd0, min_ticks} : iv_in;
        free_idx = -1;
        for (int i = NSLOT - 1; i >= 0; i--)
          if (!armed[i]) free_idx = i;
        if (free_idx < 0) begin
          n_full++;
          owe_reply(make_reply(KIND_ADD, '0, STAT_FULL, 1'b0, '0, 1'b1));
        end else begin
          armed[free_idx] = 1'b1;
          once_mark[free_idx] = os;
          period_ticks[free_idx] = iv;
          deadline[free_idx] = now_ticks + iv;
          owe_reply(make_reply(KIND_ADD, 4'(free_idx), STAT_OK, 1'b0, '0, 1'b1));
        end
      end
      OP_REMOVE: begin
        n_remove++;
        if (armed[h]) begin
          armed[h] = 1'b0;
          owe_reply(make_reply(KIND_REMOVE, h, STAT_OK, 1'b0, '0, 1'b1));
        end else begin
          n_not_used++;
          owe_reply(make_reply(KIND_REMOVE, h, STAT_NOT_USED, 1'b0, '0, 1'b1));
        end
      end
      OP_TICK: begin
        n_tick++;
        now_ticks = now_ticks + 32'd1;
        for (int i = 0; i < NSLOT; i++) begin
          if (armed[i]) begin
            lag = now_ticks - deadline[i];
            if (!lag[31]) begin
              n_fired++;
              owe_reply(make_reply(KIND_FIRED, 4'(i), STAT_OK, 1'b0, '0, 1'b0));
              if (once_mark[i]) armed[i] = 1'b0;
              else deadline[i] = now_ticks + period_ticks[i];
            end
          end
        end
        // earliest deadline counted in ticks ahead of now, lowest slot wins ties
        pend = 1'b0;
        best_ahead = '0;
        best_dl = '0;
        for (int i = 0; i < NSLOT; i++) begin
          if (armed[i]) begin
            ahead = deadline[i] - now_ticks;
            if (!pend || ahead < best_ahead) begin
              pend = 1'b1;
              best_ahead = ahead;
              best_dl = deadline[i];
            end
          end
        end
        owe_reply(make_reply(KIND_SUMMARY, '0, STAT_OK, pend, best_dl, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string why, input result_t want, input result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0d (%s): expected kind=%0d slot=%0d status=%0d pend=%0b next=%h last=%0b",
               mismatch_count, why, want.kind, want.slot, want.status, want.has_pending,
               want.next_deadline, want.last);
    if (mismatch_count <= 10)
      $display("    actual   kind=%0d slot=%0d status=%0d pend=%0b next=%h last=%0b",
               got.kind, got.slot, got.status, got.has_pending, got.next_deadline, got.last);
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = make_reply(out_kind, out_slot, out_status, out_has_pending, out_next_deadline,
                       out_last);
      if (owed_replies.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = owed_replies.pop_front();
        if (got.kind !== want.kind || got.slot !== want.slot || got.status !== want.status ||
            got.has_pending !== want.has_pending ||
            got.next_deadline !== want.next_deadline || got.last !== want.last)
          flag_mismatch("field differs", want, got);
      end
    end
  end

  // one transaction on the input channel; valid stays high on return
  task automatic send_op(input logic [OP_W-1:0] op, input logic [IV_W-1:0] iv,
                         input logic os, input logic [HANDLE_W-1:0] h);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_interval_ticks <= iv;
    in_one_shot <= os;
    in_handle <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_timer_table(op, iv, os, h);
  endtask

  task automatic drain_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_interval(input logic [MINIV_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_min_interval <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    min_ticks = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // fills every slot with extreme and ordinary intervals, then one add too many
  task automatic test_add_extremes_and_full();
    send_op(OP_ADD, 32'd0, 1'b0, 4'd0);
    send_op(OP_ADD, 32'hFFFF_FFFF, 1'b1, 4'd0);
    send_op(OP_ADD, 32'd1, 1'b0, 4'd0);
    send_op(OP_ADD, 32'd15, 1'b1, 4'd0);
    send_op(OP_ADD, 32'd16, 1'b0, 4'd0);
    send_op(OP_ADD, 32'h8000_0000, 1'b0, 4'd0);
    send_op(OP_ADD, 32'h7FFF_FFFF, 1'b0, 4'd0);
    for (int i = 7; i < NSLOT; i++)
      send_op(OP_ADD, $urandom_range(40), i[0], 4'($urandom_range(15)));
    send_op(OP_ADD, 32'd20, 1'b0, 4'd15);
  endtask

  task automatic test_remove_cases();
    send_op(OP_REMOVE, 32'd0, 1'b0, 4'd3);
    send_op(OP_REMOVE, 32'hFFFF_FFFF, 1'b1, 4'd3);
  endtask

  // the all-ones interval wraps behind now and is due on the first tick
  task automatic test_tick_wrap();
    send_op(OP_TICK, 32'd0, 1'b0, 4'd0);
    send_op(OP_TICK, 32'hFFFF_FFFF, 1'b1, 4'd15);
  endtask

  task automatic test_unused_opcode();
    send_op(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 4'd15);
  endtask

  task automatic test_zero_minimum();
    drain_replies();
    write_min_interval(16'd0);
    send_op(OP_ADD, 32'd0, 1'b0, 4'd0);
    send_op(OP_TICK, 32'd0, 1'b0, 4'd0);
    send_op(OP_TICK, 32'd0, 1'b0, 4'd0);
  endtask

  task automatic run_random_phase(input logic [MINIV_W-1:0] min_val, input int pct);
    int sent, r, pick;
    logic [IV_W-1:0] iv;
    logic [HANDLE_W-1:0] h;
    drain_replies();
    idle_pct = pct;
    write_min_interval(min_val);
    // start from an empty table so every fill level is passed through
    for (int i = 0; i < NSLOT; i++)
      if (armed[i]) send_op(OP_REMOVE, $urandom, 1'($urandom_range(1)), 4'(i));
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      r = $urandom_range(99);
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: iv = $urandom_range(40);
        6: iv = $urandom;
        7: iv = 32'h7FFF_FFF0 + $urandom_range(31);
        8: iv = {16'd0, min_ticks} + $urandom_range(3);
        default: iv = '0;
      endcase
      h = 4'($urandom_range(15));
      if ($urandom_range(9) < 7) begin
        pick = $urandom_range(15);
        for (int k = 0; k < NSLOT; k++)
          if (armed[(pick + k) % NSLOT]) h = 4'((pick + k) % NSLOT);
      end
      if (r < 30) begin
        send_op(OP_ADD, iv, 1'($urandom_range(1)), h);
        sent++;
      end else if (r < 50) begin
        send_op(OP_REMOVE, iv, 1'($urandom_range(1)), h);
        sent++;
      end else if (r < 96) begin
        send_op(OP_TICK, iv, 1'($urandom_range(1)), h);
        sent++;
      end else begin
        send_op(OP_UNUSED, iv, 1'($urandom_range(1)), h);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_ADD;
    in_interval_ticks = '0;
    in_one_shot = 1'b0;
    in_handle = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_min_interval = MIN_INTERVAL_RST;
    now_ticks = '0;
    min_ticks = MIN_INTERVAL_RST;
    for (int i = 0; i < NSLOT; i++) begin
      armed[i] = 1'b0;
      once_mark[i] = 1'b0;
      period_ticks[i] = '0;
      deadline[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_add_extremes_and_full();
    test_remove_cases();
    test_tick_wrap();
    test_unused_opcode();
    test_zero_minimum();

    run_random_phase(16'd1, 35);
    run_random_phase(16'hFFFF, 35);
    run_random_phase(16'($urandom_range(2, 30)), 0);
    run_random_phase(16'd0, 35);
    run_random_phase(MIN_INTERVAL_RST, 35);
    drain_replies();

    $display("covered %0d adds (%0d into a full table), %0d removes (%0d of free slots), %0d ticks",
             n_add, n_full, n_remove, n_not_used, n_tick);
    $display("%0d firings checked under minimum intervals 0, 1, 15, 65535 and a random one",
             n_fired);
    if (mismatch_count == 0 && owed_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
